FILE: hw/rtl/bvm_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor package
// Register map, state codes, arithmetic constants and the discharge curve.
// ----------------------------------------------------------------------------
package bvm_pkg;

  localparam int unsigned AddrW   = 4;
  localparam int unsigned PDataW  = 32;

  localparam logic [1:0] REG_DIVIDER   = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd2;

  localparam logic [15:0] DIVIDER_RST   = 16'd12288;
  localparam logic [15:0] THRESHOLD_RST = 16'd4250;
  localparam logic [3:0]  DEBOUNCE_RST  = 4'd5;

  // full-scale millivolts of the converter
  localparam logic [24:0] FULL_SCALE_MV = 25'd3300;
  // ceil(2^28 / 10): exact division by ten for 24-bit magnitudes
  localparam logic [24:0] RECIP_TEN     = 25'd26843546;
  localparam logic [13:0] MOD_ONE       = 14'd4095;
  localparam logic [13:0] MOD_TWO       = 14'd8190;

  localparam int unsigned NumSteps = 11;

  typedef logic [15:0] step_mv_t  [NumSteps];
  typedef logic [6:0]  step_pct_t [NumSteps];

  localparam step_mv_t STEP_MV = '{
    16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800, 16'd3700,
    16'd3600, 16'd3500, 16'd3400, 16'd3300, 16'd3200
  };
  localparam step_pct_t STEP_PCT = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd5
  };

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL1 = 8'b0000_0010,
    ST_MUL2 = 8'b0000_0100,
    ST_DIV1 = 8'b0000_1000,
    ST_DIV2 = 8'b0001_0000,
    ST_MUL3 = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  function automatic logic [6:0] percent_of(input logic [15:0] mv);
    logic [6:0] pct;
    pct = 7'd0;
    for (int i = NumSteps - 1; i >= 0; i--) begin
      if (mv >= STEP_MV[i]) begin
        pct = STEP_PCT[i];
      end
    end
    return pct;
  endfunction

endpackage

FILE: hw/rtl/battery_voltage_monitor.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor
// Scales ADC codes to millivolts, smooths them, grades charge level and
// reports a debounced charging flag. One shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
// One item in flight: a new input is accepted only when idle, after the
// last reading entered the output register (seeding skips the filter
//   update), due to the shared 24x25 multiplier and divide-by-4095 folds.
// Reset: asynchronous, active low; filter empty, next item seeds it,
//   charging flag clear, registers at their defaults.
module battery_voltage_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] raw_adc
  input  logic        s_axis_tuser,   // [0] reseed
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] voltage_mv, [22:16] percent
  output logic        m_axis_tuser,   // [0] charging
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bvm_pkg::AddrW-1:0]  paddr,
  input  logic [bvm_pkg::PDataW-1:0] pwdata,
  output logic [bvm_pkg::PDataW-1:0] prdata,
  output logic                       pready
);

  bvm_pkg::state_e state_q, state_d;

  logic [15:0] divider_q;
  logic [15:0] threshold_q;
  logic [3:0]  debounce_q;

  logic [11:0] raw_q;
  logic        reseed_q;
  logic        first_q;
  logic [23:0] smooth_q, smooth_d;
  logic        cand_q, cand_d;
  logic [3:0]  agree_q, agree_d;
  logic        flag_q, flag_d;

  logic [48:0] prod_q;
  logic [23:0] mul_a;
  logic [24:0] mul_b;
  logic [23:0] t_q;
  logic [24:0] u_q;
  logic [23:0] mag_q;
  logic        neg_q;

  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic        out_flag_q;

  logic        wr_en;
  logic [1:0]  reg_idx;

  logic [12:0] t2;
  logic [13:0] w;
  logic [1:0]  carry;
  logic [23:0] v_q8;
  logic [24:0] diff;
  logic [20:0] quot;
  logic        sample;
  logic [3:0]  agree_inc;
  logic        out_free;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divider_q   <= bvm_pkg::DIVIDER_RST;
      threshold_q <= bvm_pkg::THRESHOLD_RST;
      debounce_q  <= bvm_pkg::DEBOUNCE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        bvm_pkg::REG_DIVIDER:   divider_q   <= pwdata[15:0];
        bvm_pkg::REG_THRESHOLD: threshold_q <= pwdata[15:0];
        bvm_pkg::REG_DEBOUNCE:  debounce_q  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bvm_pkg::REG_DIVIDER:   prdata = {16'd0, divider_q};
      bvm_pkg::REG_THRESHOLD: prdata = {16'd0, threshold_q};
      bvm_pkg::REG_DEBOUNCE:  prdata = {28'd0, debounce_q};
      default:                prdata = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      bvm_pkg::ST_MUL1: begin
        mul_a = {12'd0, raw_q};
        mul_b = bvm_pkg::FULL_SCALE_MV;
      end
      bvm_pkg::ST_MUL2: begin
        mul_a = prod_q[23:0];
        mul_b = {9'd0, divider_q};
      end
      default: begin
        mul_a = mag_q;
        mul_b = bvm_pkg::RECIP_TEN;
      end
    endcase
  end

  // divide by 4095 second fold and filter difference
  assign t2    = u_q[24:12];
  assign w     = {1'b0, t2} + {2'd0, u_q[11:0]};
  assign carry = (w >= bvm_pkg::MOD_TWO) ? 2'd2 :
                 (w >= bvm_pkg::MOD_ONE) ? 2'd1 : 2'd0;
  assign v_q8  = t_q + {11'd0, t2} + {22'd0, carry};
  assign diff  = {1'b0, v_q8} - {1'b0, smooth_q};
  assign quot  = prod_q[48:28];

  // debounce
  assign sample    = smooth_q > {threshold_q, 8'd0};
  assign agree_inc = (agree_q < debounce_q) ? agree_q + 4'd1 : agree_q;
  assign out_free  = !out_valid_q || m_axis_tready;

  always_comb begin
    cand_d  = cand_q;
    agree_d = agree_q;
    flag_d  = flag_q;
    if (sample == cand_q) begin
      agree_d = agree_inc;
      if (agree_inc >= debounce_q) begin
        flag_d = sample;
      end
    end else begin
      cand_d  = sample;
      agree_d = 4'd1;
    end
  end

  always_comb begin
    state_d  = state_q;
    smooth_d = smooth_q;
    case (state_q)
      bvm_pkg::ST_IDLE: if (s_axis_tvalid) state_d = bvm_pkg::ST_MUL1;
      bvm_pkg::ST_MUL1: state_d = bvm_pkg::ST_MUL2;
      bvm_pkg::ST_MUL2: state_d = bvm_pkg::ST_DIV1;
      bvm_pkg::ST_DIV1: state_d = bvm_pkg::ST_DIV2;
      bvm_pkg::ST_DIV2: begin
        if (first_q || reseed_q) begin
          smooth_d = v_q8;
          state_d  = bvm_pkg::ST_OUT;
        end else begin
          state_d  = bvm_pkg::ST_MUL3;
        end
      end
      bvm_pkg::ST_MUL3: state_d = bvm_pkg::ST_UPD;
      bvm_pkg::ST_UPD: begin
        smooth_d = neg_q ? smooth_q - {3'd0, quot} : smooth_q + {3'd0, quot};
        state_d  = bvm_pkg::ST_OUT;
      end
      bvm_pkg::ST_OUT: if (out_free) state_d = bvm_pkg::ST_IDLE;
      default: state_d = bvm_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == bvm_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bvm_pkg::ST_IDLE;
      first_q     <= 1'b1;
      smooth_q    <= '0;
      cand_q      <= 1'b0;
      agree_q     <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      smooth_q <= smooth_d;
      if (state_q == bvm_pkg::ST_DIV2 && (first_q || reseed_q)) begin
        first_q <= 1'b0;
      end
      if (state_q == bvm_pkg::ST_OUT && out_free) begin
        cand_q      <= cand_d;
        agree_q     <= agree_d;
        flag_q      <= flag_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      raw_q    <= s_axis_tdata[11:0];
      reseed_q <= s_axis_tuser;
    end
    prod_q <= 49'(mul_a * mul_b);
    if (state_q == bvm_pkg::ST_DIV1) begin
      t_q <= prod_q[39:16];
      u_q <= {1'b0, prod_q[39:16]} + {13'd0, prod_q[15:4]};
    end
    if (state_q == bvm_pkg::ST_DIV2) begin
      neg_q <= diff[24];
      mag_q <= diff[24] ? 24'(-diff) : diff[23:0];
    end
    if (state_q == bvm_pkg::ST_OUT && out_free) begin
      out_data_q <= {1'b0, bvm_pkg::percent_of(smooth_q[23:8]), smooth_q[23:8]};
      out_flag_q <= flag_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flag_q;

endmodule

FILE: tb/sv/bvm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery voltage monitor checker
// Watches the sample stream, the reading stream and the register port,
// predicts each reading from its own copy of the gauge state and compares
// every accepted reading field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bvm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] in_data_i,
  input  logic        in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,
  input  logic        out_user_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [bvm_pkg::AddrW-1:0]  paddr_i,
  input  logic [bvm_pkg::PDataW-1:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam logic [39:0] ADC_FULL_MV = 40'd3300;
  localparam logic [39:0] SCALE_DIV   = 40'd65520;

  typedef struct packed {
    logic [15:0] mv;
    logic [6:0]  pct;
    logic        chg;
  } reading_t;

  reading_t    expected_readings[$];

  logic [15:0] div_cfg;
  logic [15:0] thr_cfg;
  logic [3:0]  deb_cfg;

  logic [23:0] filt_q8;
  logic        awaiting_seed;
  logic        cand_level;
  logic [3:0]  agree_cnt;
  logic        chg_flag;

  function automatic logic [6:0] grade_level(input logic [15:0] mv);
    logic [6:0] pct;
    if (mv >= 16'd4200) begin
      pct = 7'd100;
    end else if (mv >= 16'd3300) begin
      pct = 7'((mv - 16'd3200) / 16'd100 * 16'd10);
    end else if (mv >= 16'd3200) begin
      pct = 7'd5;
    end else begin
      pct = 7'd0;
    end
    return pct;
  endfunction

  function automatic reading_t advance_gauge(input logic [11:0] raw, input logic reseed);
    logic [39:0] prod;
    logic [23:0] v_q8;
    longint      diff;
    longint      nxt;
    logic        above;
    reading_t    rd;
    prod = 40'(raw) * ADC_FULL_MV * 40'(div_cfg);
    v_q8 = 24'(prod / SCALE_DIV);
    if (awaiting_seed || reseed) begin
      filt_q8 = v_q8;
      awaiting_seed = 1'b0;
    end else begin
      diff = longint'(v_q8) - longint'(filt_q8);
      nxt = longint'(filt_q8) + diff / 10;
      filt_q8 = 24'(nxt);
    end
    above = {8'd0, filt_q8} > {8'd0, thr_cfg, 8'd0};
    if (above == cand_level) begin
      if (agree_cnt < deb_cfg) begin
        agree_cnt = agree_cnt + 4'd1;
      end
      if (agree_cnt >= deb_cfg) begin
        chg_flag = above;
      end
    end else begin
      cand_level = above;
      agree_cnt = 4'd1;
    end
    rd.mv = filt_q8[23:8];
    rd.pct = grade_level(filt_q8[23:8]);
    rd.chg = chg_flag;
    return rd;
  endfunction

  function automatic void report(input string what, input int exp_v, input int act_v);
    fail_count_o++;
    $display("%0t ns: %s expected %0d, got %0d", $time, what, exp_v, act_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t exp_rd;
    if (!rst_ni) begin
      div_cfg = bvm_pkg::DIVIDER_RST;
      thr_cfg = bvm_pkg::THRESHOLD_RST;
      deb_cfg = bvm_pkg::DEBOUNCE_RST;
      filt_q8 = '0;
      awaiting_seed = 1'b1;
      cand_level = 1'b0;
      agree_cnt = '0;
      chg_flag = 1'b0;
      expected_readings.delete();
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          bvm_pkg::REG_DIVIDER:   div_cfg = pwdata_i[15:0];
          bvm_pkg::REG_THRESHOLD: thr_cfg = pwdata_i[15:0];
          bvm_pkg::REG_DEBOUNCE:  deb_cfg = pwdata_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          report("unexpected reading, voltage_mv", -1, int'(out_data_i[15:0]));
        end else begin
          exp_rd = expected_readings.pop_front();
          checked_o++;
          if (out_data_i[15:0] != exp_rd.mv) begin
            report("voltage_mv", int'(exp_rd.mv), int'(out_data_i[15:0]));
          end
          if (out_data_i[22:16] != exp_rd.pct) begin
            report("percent", int'(exp_rd.pct), int'(out_data_i[22:16]));
          end
          if (out_user_i != exp_rd.chg) begin
            report("charging", int'(exp_rd.chg), int'(out_user_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_readings.push_back(advance_gauge(in_data_i[11:0], in_user_i));
      end
      pending_o = expected_readings.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Battery voltage monitor testbench
// Drives ADC samples and register writes into the monitor under random
// source gaps and sink stalls, with two long sink hold-offs; the checker
// predicts and compares every reading and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_CYCLES     = 400;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 172;

  logic        clk_i;
  logic        rst_n    = 1'b0;
  logic        s_valid  = 1'b0;
  logic        s_ready;
  logic [15:0] s_data   = '0;
  logic        s_user   = 1'b0;
  logic        m_valid;
  logic        m_ready  = 1'b0;
  logic [23:0] m_data;
  logic        m_user;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [bvm_pkg::AddrW-1:0]  paddr  = '0;
  logic [bvm_pkg::PDataW-1:0] pwdata = '0;
  logic [bvm_pkg::PDataW-1:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          checked;
  int          samples_sent = 0;
  int          settings_used = 1;
  logic        gaps_on = 1'b1;
  logic        hold_req = 1'b0;

  battery_voltage_monitor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bvm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .in_user_i    (s_user),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_user_i   (m_user),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles with %0d readings outstanding", CYCLE_LIMIT, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        m_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        m_ready <= 1'b1;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [11:0] raw, input logic reseed);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {4'd0, raw};
    s_user <= reseed;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int          level;
    int          raw_v;
    int          mv;
    logic [15:0] div;
    logic [15:0] thr;
    logic [3:0]  deb;
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd4095, 1'b1);
    repeat (5) send_sample(12'd4095, 1'b0);
    send_sample(12'd1, 1'b1);
    send_sample(12'd2048, 1'b0);
    for (int k = 0; k <= 11; k++) begin
      mv = 4200 - 100 * k;
      send_sample(12'((mv * 4095 + 9899) / 9900), 1'b1);
    end
    send_sample(12'd1737, 1'b1);
    drain();

    level = 1700;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          div = 16'hFFFF;
          thr = 16'd0;
          deb = 4'd1;
        end
        1: begin
          div = 16'd2048;
          thr = 16'hFFFF;
          deb = 4'd15;
        end
        2: begin
          div = 16'($urandom_range(0, 2047));
          deb = 4'd0;
        end
        default: begin
          div = 16'($urandom_range(2048, 65535));
          deb = 4'($urandom_range(1, 15));
        end
      endcase
      if (p >= 2) begin
        thr = 16'($urandom_range(0, (3300 * int'(div)) / 4096));
      end
      write_reg(bvm_pkg::REG_DIVIDER, div);
      write_reg(bvm_pkg::REG_THRESHOLD, thr);
      write_reg(bvm_pkg::REG_DEBOUNCE, deb);
      settings_used++;
      gaps_on = (p < NUM_PHASES - 2);
      if (p == 1 || p == 4) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          level = $urandom_range(0, 4095);
        end
        if ($urandom_range(0, 7) == 0) begin
          raw_v = $urandom_range(0, 4095);
        end else begin
          raw_v = level + $urandom_range(0, 80) - 40;
          if (raw_v < 0) raw_v = 0;
          if (raw_v > 4095) raw_v = 4095;
        end
        send_sample(12'(raw_v), $urandom_range(0, 19) == 0);
      end
      drain();
    end

    repeat (16) @(negedge clk_i);
    $display("Covered %0d samples under %0d register settings, %0d readings compared",
             samples_sent, settings_used, checked);
    $display("Settings included extreme and below-range dividers, zero debounce, long stall");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
